// ===== rtl/core/brle_pkg.sv =====
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the bitmap scanline decoder.
// ----------------------------------------------------------------------------
package brle_pkg;

	localparam int MaxDim = 16384;
	localparam int Lanes = 8;
	localparam logic [3:0] NibMask = 4'hf;

	typedef enum logic [1:0] {
		MODE_RAW  = 2'd0,
		MODE_RLE8 = 2'd1,
		MODE_RLE4 = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CFG_MODE   = 3'd0,
		CFG_WIDTH  = 3'd1,
		CFG_HEIGHT = 3'd2,
		CFG_BOTUP  = 3'd3,
		CFG_RAWROW = 3'd4,
		CFG_RAWPAD = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_MARKER  = 3'd0,
		PH_RUN     = 3'd1,
		PH_ESCAPE  = 3'd2,
		PH_ABS     = 3'd3,
		PH_ABS_PAD = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EOB   = 2'd1,
		ST_DELTA = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		C_IDLE = 2'd0,
		C_EMIT = 2'd1,
		C_OUT  = 2'd2
	} cstate_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch input byte, process it
		logic step;   // emit one more group of the current run
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic more;   // run still has groups to emit
		logic has_out; // a result is waiting in the holding register
	} sts_t;

endpackage

// ===== rtl/core/brle_ctrl.sv =====
// ----------------------------------------------------------------------------
// brle_ctrl
// Sequencer: takes a byte, then steps the run until all groups are out.
// ----------------------------------------------------------------------------
module brle_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	input  brle_pkg::sts_t   sts,
	output brle_pkg::cmd_t   cmd
);
	import brle_pkg::*;

	cstate_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= C_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		unique case (state_q)
			C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = C_EMIT;
				end
			end
			C_EMIT: begin
				// datapath has evaluated; a result may be present
				if (sts.has_out) state_d = C_OUT;
				else if (sts.more) cmd.step = 1'b1;
				else state_d = C_IDLE;
			end
			C_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.more) begin
						cmd.step = 1'b1;
						state_d = C_EMIT;
					end else begin
						state_d = C_IDLE;
					end
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/brle_dp.sv =====
// ----------------------------------------------------------------------------
// brle_dp
// Datapath: decode state, run expansion one group per step, result register.
// ----------------------------------------------------------------------------
module brle_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  brle_pkg::cmd_t   cmd,
	output brle_pkg::sts_t   sts,
	input  logic [7:0]       stream_byte,
	input  logic             out_ack,
	input  logic [1:0]       decode_mode,
	input  logic [14:0]      image_width,
	input  logic [14:0]      image_height,
	input  logic             bottom_up,
	input  logic [16:0]      raw_row_bytes,
	input  logic [1:0]       raw_pad_bytes,
	output logic [63:0]      pixel_group,
	output logic [3:0]       pixel_count,
	output logic [15:0]      column,
	output logic [13:0]      row,
	output logic [1:0]       status,
	output logic             frame_end,
	output logic             last
);
	import brle_pkg::*;

	phase_t      phase_q;
	logic [7:0]  run_count_q;
	logic [7:0]  held_byte_q;
	logic        pad_pending_q;
	logic [16:0] column_pos_q;
	logic [14:0] row_pos_q;
	logic        row_just_filled_q;
	logic [1:0]  raw_pad_left_q;
	logic [1:0]  halted_q;
	logic        four_q;
	// run expansion
	logic        run_act_q;   // groups remain
	logic [8:0]  run_left_q;  // pixels of the current command still to place
	logic        run_odd_q;   // next pixel index is odd (RLE4 phase)
	logic        run_abs_q;   // absolute-data command (vs encoded run)
	// result holding register
	logic        has_q;
	logic [63:0] grp_q;
	logic [3:0]  cnt_q;
	logic [15:0] col_q;
	logic [13:0] row_q;
	logic [1:0]  st_q;
	logic        fe_q, last_q;

	logic [14:0] w_eff, h_eff;
	logic [16:0] rb_eff;
	logic        dimmax;
	logic [13:0] drow;
	logic        w_full;

	assign w_eff = (image_width > 15'(MaxDim)) ? 15'(MaxDim) : image_width;
	assign h_eff = (image_height > 15'(MaxDim)) ? 15'(MaxDim) : image_height;
	assign rb_eff = (raw_row_bytes == '0) ? 17'd1 : raw_row_bytes;
	assign dimmax = (row_pos_q >= h_eff);
	assign drow = dimmax ? 14'd0 : (bottom_up ? 14'(h_eff - 15'd1 - row_pos_q)
		: row_pos_q[13:0]);
	assign w_full = (column_pos_q >= {2'b0, w_eff});

	// group formation for a step of the run
	logic [16:0] space;
	logic [3:0]  take;
	logic [63:0] grp;
	logic [3:0]  nib_hi, nib_lo;
	logic [7:0]  pa, pb;

	assign nib_hi = held_byte_q[7:4] & NibMask;
	assign nib_lo = held_byte_q[3:0] & NibMask;
	assign space = {2'b0, w_eff} - column_pos_q;

	always_comb begin
		take = (run_left_q > 9'(Lanes)) ? 4'(Lanes) : run_left_q[3:0];
		if (w_full) take = '0;
		else if ({13'b0, take} > space) take = space[3:0];
		pa = four_q ? {4'b0, run_odd_q ? nib_lo : nib_hi} : held_byte_q;
		pb = four_q ? {4'b0, run_odd_q ? nib_hi : nib_lo} : held_byte_q;
		grp = '0;
		for (int k = 0; k < Lanes; k++) begin
			if (4'(k) < take) grp[8*k +: 8] = k[0] ? pb : pa;
		end
	end

	assign sts.more = run_act_q;
	assign sts.has_out = has_q;

	// end-of-command bookkeeping: the command ends on the group that fills the
	// row or places its last pixel; pixels past the row end are dropped
	logic        cmd_end;
	logic [16:0] col_step, col_next;

	assign col_step = column_pos_q + {13'b0, take};
	assign col_next = column_pos_q + {8'b0, run_left_q};
	assign cmd_end = w_full || (run_left_q == {5'b0, take}) || ({13'b0, take} == space);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARKER;
			run_count_q <= '0;
			held_byte_q <= '0;
			pad_pending_q <= 1'b0;
			column_pos_q <= '0;
			row_pos_q <= '0;
			row_just_filled_q <= 1'b0;
			raw_pad_left_q <= '0;
			halted_q <= '0;
			four_q <= 1'b0;
			run_act_q <= 1'b0;
			run_left_q <= '0;
			run_odd_q <= 1'b0;
			run_abs_q <= 1'b0;
			has_q <= 1'b0;
			grp_q <= '0;
			cnt_q <= '0;
			col_q <= '0;
			row_q <= '0;
			st_q <= '0;
			fe_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (out_ack) has_q <= 1'b0;
			if (cmd.load) begin
				grp_q <= '0; cnt_q <= '0; col_q <= '0; row_q <= '0; st_q <= '0;
				fe_q <= 1'b0; last_q <= 1'b1;
				four_q <= (decode_mode == MODE_RLE4);
				if (halted_q != '0) begin
					has_q <= 1'b1;
					st_q <= halted_q;
				end else if (dimmax) begin
					has_q <= 1'b0;
				end else if (decode_mode != MODE_RLE8 && decode_mode != MODE_RLE4) begin
					if (raw_pad_left_q != '0) begin
						raw_pad_left_q <= raw_pad_left_q - 2'd1;
					end else begin
						has_q <= 1'b1;
						grp_q <= {56'b0, stream_byte};
						cnt_q <= 4'd1;
						col_q <= column_pos_q[15:0];
						row_q <= drow;
						if (column_pos_q + 17'd1 >= rb_eff) begin
							column_pos_q <= '0;
							row_pos_q <= row_pos_q + 15'd1;
							raw_pad_left_q <= raw_pad_bytes;
							fe_q <= (row_pos_q + 15'd1 >= h_eff);
						end else begin
							column_pos_q <= column_pos_q + 17'd1;
						end
					end
				end else begin
					unique case (phase_q)
						PH_MARKER: begin
							if (stream_byte == 8'd0) phase_q <= PH_ESCAPE;
							else begin
								row_just_filled_q <= 1'b0;
								run_count_q <= stream_byte;
								phase_q <= PH_RUN;
							end
						end
						PH_ESCAPE: begin
							if (stream_byte == 8'd0) begin
								phase_q <= PH_MARKER;
								if (row_just_filled_q) row_just_filled_q <= 1'b0;
								else begin
									column_pos_q <= '0;
									row_pos_q <= row_pos_q + 15'd1;
									if (row_pos_q + 15'd1 >= h_eff) begin
										has_q <= 1'b1;
										fe_q <= 1'b1;
									end
								end
							end else if (stream_byte == 8'd1 || stream_byte == 8'd2) begin
								row_just_filled_q <= 1'b0;
								phase_q <= PH_MARKER;
								halted_q <= stream_byte[1:0];
								has_q <= 1'b1;
								st_q <= stream_byte[1:0];
							end else begin
								row_just_filled_q <= 1'b0;
								run_count_q <= stream_byte;
								pad_pending_q <= (decode_mode == MODE_RLE4)
									? (stream_byte[1] ^ stream_byte[0]) : stream_byte[0];
								phase_q <= PH_ABS;
							end
						end
						PH_RUN: begin
							held_byte_q <= stream_byte;
							run_left_q <= {1'b0, run_count_q};
							run_count_q <= '0;
							run_odd_q <= 1'b0;
							run_abs_q <= 1'b0;
							run_act_q <= 1'b1;
						end
						PH_ABS: begin
							held_byte_q <= stream_byte;
							run_odd_q <= 1'b0;
							run_abs_q <= 1'b1;
							run_act_q <= 1'b1;
							if (decode_mode == MODE_RLE4) begin
								run_left_q <= (run_count_q >= 8'd2) ? 9'd2 : {1'b0, run_count_q};
								run_count_q <= (run_count_q >= 8'd2) ? run_count_q - 8'd2 : '0;
							end else begin
								run_left_q <= 9'd1;
								run_count_q <= run_count_q - 8'd1;
							end
						end
						PH_ABS_PAD: begin
							pad_pending_q <= 1'b0;
							phase_q <= PH_MARKER;
							if (w_full) begin
								row_just_filled_q <= (column_pos_q == {2'b0, w_eff});
								column_pos_q <= '0;
								row_pos_q <= row_pos_q + 15'd1;
								if (row_pos_q + 15'd1 >= h_eff) begin
									has_q <= 1'b1;
									fe_q <= 1'b1;
								end
							end
						end
						default: phase_q <= PH_MARKER;
					endcase
				end
			end else if (cmd.step) begin
				// emit one group (possibly empty when the row is full)
				if (take != '0) begin
					has_q <= 1'b1;
					grp_q <= grp;
					cnt_q <= take;
					col_q <= column_pos_q[15:0];
					row_q <= drow;
					st_q <= ST_OK;
					fe_q <= 1'b0;
					last_q <= 1'b0;
				end
				run_odd_q <= run_odd_q ^ take[0];
				if (!cmd_end) begin
					run_left_q <= run_left_q - {5'b0, take};
					column_pos_q <= col_step;
				end else begin
					// remaining dropped pixels still advance the column
					run_act_q <= 1'b0;
					run_left_q <= '0;
					last_q <= 1'b1;
					if (!run_abs_q || run_count_q == '0) begin
						if (run_abs_q && pad_pending_q) begin
							phase_q <= PH_ABS_PAD;
							column_pos_q <= col_next;
						end else begin
							phase_q <= PH_MARKER;
							if (col_next >= {2'b0, w_eff}) begin
								row_just_filled_q <= (col_next == {2'b0, w_eff});
								column_pos_q <= '0;
								row_pos_q <= row_pos_q + 15'd1;
								if (row_pos_q + 15'd1 >= h_eff) begin
									fe_q <= 1'b1;
									if (take == '0) begin
										has_q <= 1'b1;
										grp_q <= '0; cnt_q <= '0; col_q <= '0;
										row_q <= '0; st_q <= ST_OK;
									end
								end
							end else begin
								column_pos_q <= col_next;
							end
						end
					end else begin
						column_pos_q <= col_next;
					end
				end
			end
		end
	end

	assign pixel_group = grp_q;
	assign pixel_count = cnt_q;
	assign column = col_q;
	assign row = row_q;
	assign status = st_q;
	assign frame_end = fe_q;
	assign last = last_q;

endmodule

// ===== rtl/core/bitmap_rle_scanline_decoder_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_rle_scanline_decoder_top
// Raw / RLE8 / RLE4 bitmap stream decoder giving groups of pixel indices.
// ----------------------------------------------------------------------------
// One stream byte is taken per transaction, and the next is taken only once
// every result of the previous one has left. A byte whose single result comes
// straight from the byte (raw pixel, status, end of line that completes the
// frame) is offered from the output register. A run byte that yields pixel
// groups steps the run sequencer once per group, and each group then waits
// in the output register; a group holds up to eight pixels. While out_ready
// is held low, an offered result stalls the block. After the end-of-bitmap
// or delta escape the block is halted and answers every byte with the same
// status result; only a reset restarts it. Write configuration only while
// idle.
module bitmap_rle_scanline_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] pixel_group,
	output logic [3:0]  pixel_count,
	output logic [15:0] column,
	output logic [13:0] row,
	output logic [1:0]  status,
	output logic        frame_end,
	output logic        last
);
	import brle_pkg::*;

	logic [1:0]  mode_q;
	logic [14:0] width_q, height_q;
	logic        botup_q;
	logic [16:0] rawrow_q;
	logic [1:0]  rawpad_q;
	cmd_t        cmd;
	sts_t        sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAW;
			width_q <= 15'd1;
			height_q <= 15'd1;
			botup_q <= 1'b1;
			rawrow_q <= 17'd1;
			rawpad_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q <= cfg_data[1:0];
				CFG_WIDTH:  width_q <= cfg_data[14:0];
				CFG_HEIGHT: height_q <= cfg_data[14:0];
				CFG_BOTUP:  botup_q <= cfg_data[0];
				CFG_RAWROW: rawrow_q <= cfg_data;
				CFG_RAWPAD: rawpad_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	brle_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_ready(out_ready), .out_valid(out_valid),
		.sts(sts), .cmd(cmd)
	);

	brle_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.stream_byte(stream_byte), .out_ack(out_valid & out_ready),
		.decode_mode(mode_q), .image_width(width_q), .image_height(height_q),
		.bottom_up(botup_q), .raw_row_bytes(rawrow_q), .raw_pad_bytes(rawpad_q),
		.pixel_group(pixel_group), .pixel_count(pixel_count), .column(column),
		.row(row), .status(status), .frame_end(frame_end), .last(last)
	);

endmodule
